[rtl/pidpi_pkg.sv]
// Shared constants for the PID regulator.
package pidpi_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = DataW + 1;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned GainFracBits = 8;
  localparam int unsigned FiltFracBits = 16;

  localparam logic [KindW-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KindW-1:0] KIND_STOP   = 2'd1;
  localparam logic [KindW-1:0] KIND_START  = 2'd2;
  localparam logic [KindW-1:0] KIND_RSVD   = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_GAINS      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SETPOINT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LIMITS     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLDS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALPHA      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MODE       = 3'd5;

  localparam logic [47:0] GAINS_RST      = 48'd1099520016410;
  localparam logic [30:0] LIMITS_RST     = 31'd65536500;
  localparam logic [31:0] THRESHOLDS_RST = 32'd100;
  localparam logic [2:0]  MODE_RST       = 3'd6;

endpackage

[rtl/pidpi_if.sv]
// Valid/ready channel interfaces for input items and results.
interface pidpi_in_if;
  logic                              valid;
  logic                              ready;
  logic [pidpi_pkg::KindW-1:0]       kind;
  logic signed [pidpi_pkg::DataW-1:0] measurement;
  modport source (output valid, kind, measurement, input ready);
  modport sink   (input valid, kind, measurement, output ready);
endinterface

interface pidpi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidpi_pkg::DataW-1:0] drive;
  logic signed [pidpi_pkg::ErrW-1:0]  error_now;
  logic signed [pidpi_pkg::DataW-1:0] integral_now;
  modport source (output valid, drive, error_now, integral_now, input ready);
  modport sink   (input valid, drive, error_now, integral_now, output ready);
endinterface

[rtl/pid_position_incremental.sv]
// PID regulator top level: sequencer around one shared multiplier.
// A running sample steps through filter, error, integral, three gain products and
// saturate before its result is registered; other items go straight to the result.
// A new item is taken only in idle, once the last result is registered; the shared
// multiplier serves the filter and the gain products; a held result adds its wait.
// Reset is asynchronous, active low: registers take defaults, history clears.
module pid_position_incremental (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pidpi_in_if.sink                            in_i,
  pidpi_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [pidpi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pidpi_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILT, S_SF, S_ERR, S_INT, S_M0, S_M1, S_M2, S_M3, S_SAT, S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [47:0]        gains_q;
  logic signed [15:0] setpoint_q;
  logic [30:0]        limits_q;
  logic [31:0]        thresh_q;
  logic [15:0]        alpha_q;
  logic [2:0]         mode_q;

  // controller state
  logic               running_q;
  logic signed [31:0] sf_q;
  logic signed [15:0] integ_q;
  logic signed [16:0] err_q, err1_q, err2_q;
  logic signed [15:0] outreg_q, meas_last_q, meas_prev_q;

  // working registers
  logic signed [15:0] meas_q;
  logic signed [51:0] prod_q;
  logic signed [31:0] acc_q;

  logic               out_valid_q;
  logic signed [15:0] out_drive_q, out_integ_q;
  logic signed [16:0] out_err_q;

  logic [15:0] kp, ki, kd, dead, sep, max_int;
  logic [14:0] max_out;
  logic        incr, sep_en, d_on_meas;

  assign kp        = gains_q[47:32];
  assign ki        = gains_q[31:16];
  assign kd        = gains_q[15:0];
  assign max_out   = limits_q[30:16];
  assign max_int   = limits_q[15] ? 16'h7FFF : limits_q[15:0];
  assign dead      = thresh_q[31:16];
  assign sep       = thresh_q[15:0];
  assign incr      = mode_q[0];
  assign sep_en    = mode_q[1];
  assign d_on_meas = mode_q[2];

  logic in_fire;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // shared multiplier: unsigned gain or alpha times a signed operand
  logic [16:0]        mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [32:0] sp_q33, diff;
  logic signed [18:0] e_s, e1_s, e2_s;

  assign sp_q33 = {setpoint_q[15], setpoint_q, 16'd0};
  assign diff   = sp_q33 - 33'(sf_q);
  assign e_s    = 19'(err_q);
  assign e1_s   = 19'(err1_q);
  assign e2_s   = 19'(err2_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_FILT: begin
        mul_a = {1'b0, alpha_q};
        mul_b = 34'(diff);
      end
      S_M0: begin
        mul_a = {1'b0, kp};
        mul_b = incr ? 34'(e_s - e1_s) : 34'(e_s);
      end
      S_M1: begin
        mul_a = {1'b0, ki};
        mul_b = incr ? 34'(e_s) : 34'(integ_q);
      end
      S_M2: begin
        mul_a = {1'b0, kd};
        if (incr) mul_b = 34'(e_s - (e1_s <<< 1) + e2_s);
        else if (d_on_meas) mul_b = 34'(19'(meas_prev_q) - 19'(meas_q));
        else mul_b = 34'(e_s - e1_s);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // error path with dead zone
  logic signed [16:0] err_raw, err_dz;
  logic [16:0]        err_mag, new_mag;
  assign err_raw = 17'($signed(sf_q[31:16])) - 17'(meas_q);
  assign err_mag = err_raw[16] ? 17'(-err_raw) : 17'(err_raw);
  assign err_dz  = (err_mag < {1'b0, dead}) ? '0 : err_raw;
  assign new_mag = err_q[16] ? 17'(-err_q) : 17'(err_q);

  // integral update with clamp
  logic signed [17:0] isum, ibound;
  logic signed [15:0] iclamp;
  assign isum   = 18'(integ_q) + 18'(err_q);
  assign ibound = $signed({2'b00, max_int});
  always_comb begin
    if (isum > ibound) iclamp = 16'(ibound);
    else if (isum < -ibound) iclamp = 16'(-ibound);
    else iclamp = 16'(isum);
  end

  // scaled product and output saturation
  logic signed [31:0] term, obound;
  logic signed [15:0] oclamp;
  assign term   = 32'(prod_q >>> pidpi_pkg::GainFracBits);
  assign obound = $signed({17'd0, max_out});
  always_comb begin
    if (acc_q > obound) oclamp = 16'(obound);
    else if (acc_q < -obound) oclamp = 16'(-obound);
    else oclamp = 16'(acc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gains_q     <= pidpi_pkg::GAINS_RST;
      setpoint_q  <= '0;
      limits_q    <= pidpi_pkg::LIMITS_RST;
      thresh_q    <= pidpi_pkg::THRESHOLDS_RST;
      alpha_q     <= '0;
      mode_q      <= pidpi_pkg::MODE_RST;
      running_q   <= 1'b0;
      sf_q        <= '0;
      integ_q     <= '0;
      err_q       <= '0;
      err1_q      <= '0;
      err2_q      <= '0;
      outreg_q    <= '0;
      meas_last_q <= '0;
      meas_prev_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pidpi_pkg::REG_GAINS:      gains_q    <= cfg_data_i;
          pidpi_pkg::REG_SETPOINT:   setpoint_q <= cfg_data_i[15:0];
          pidpi_pkg::REG_LIMITS:     limits_q   <= cfg_data_i[30:0];
          pidpi_pkg::REG_THRESHOLDS: thresh_q   <= cfg_data_i[31:0];
          pidpi_pkg::REG_ALPHA:      alpha_q    <= cfg_data_i[15:0];
          pidpi_pkg::REG_MODE:       mode_q     <= cfg_data_i[2:0];
          default: ;
        endcase
      end

      // drop the result once taken; S_DONE owns the flag while it is active
      if (out_valid_q && out_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            meas_q <= in_i.measurement;
            priority if (in_i.kind == pidpi_pkg::KIND_SAMPLE) begin
              if (running_q) begin
                meas_last_q <= in_i.measurement;
                state_q     <= S_FILT;
              end else begin
                // stopped: shift history only
                err2_q      <= err1_q;
                err1_q      <= err_q;
                meas_prev_q <= meas_last_q;
                state_q     <= S_DONE;
              end
            end else if (in_i.kind == pidpi_pkg::KIND_STOP) begin
              running_q   <= 1'b0;
              integ_q     <= '0;
              err_q       <= '0;
              err1_q      <= '0;
              err2_q      <= '0;
              outreg_q    <= '0;
              meas_prev_q <= meas_last_q;
              state_q     <= S_DONE;
            end else if (in_i.kind == pidpi_pkg::KIND_START) begin
              running_q <= 1'b1;
              state_q   <= S_DONE;
            end else begin
              // unused kind: report the current state only
              state_q <= S_DONE;
            end
          end
        end
        S_FILT: begin
          prod_q  <= mul_p;
          state_q <= S_SF;
        end
        S_SF: begin
          // zero alpha bypasses the low-pass filter
          if (alpha_q == '0) sf_q <= 32'(sp_q33);
          else sf_q <= sf_q + 32'(prod_q >>> pidpi_pkg::FiltFracBits);
          state_q <= S_ERR;
        end
        S_ERR: begin
          err_q   <= err_dz;
          state_q <= S_INT;
        end
        S_INT: begin
          if (incr) integ_q <= '0;
          else if (!sep_en || new_mag < {1'b0, sep}) integ_q <= iclamp;
          state_q <= S_M0;
        end
        S_M0: begin
          prod_q  <= mul_p;
          acc_q   <= incr ? 32'(outreg_q) : '0;
          state_q <= S_M1;
        end
        S_M1, S_M2: begin
          prod_q  <= mul_p;
          acc_q   <= acc_q + term;
          state_q <= (state_q == S_M1) ? S_M2 : S_M3;
        end
        S_M3: begin
          acc_q   <= acc_q + term;
          state_q <= S_SAT;
        end
        S_SAT: begin
          outreg_q    <= oclamp;
          err2_q      <= err1_q;
          err1_q      <= err_q;
          meas_prev_q <= meas_last_q;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          // hold until the previous result has been taken
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_drive_q <= outreg_q;
            out_err_q   <= err_q;
            out_integ_q <= integ_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive        = out_drive_q;
  assign out_o.error_now    = out_err_q;
  assign out_o.integral_now = out_integ_q;

`ifndef NO_ASSERTIONS
  a_int_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q != 16'sh8000) else $error("integral outside symmetric bound");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_i.ready) else $error("ready while busy");
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind == pidpi_pkg::KIND_STOP |=>
      err_q == '0 && outreg_q == '0 && integ_q == '0 && !running_q)
    else $error("stop did not clear history");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the positional/incremental PID regulator.
`timescale 1ns / 100ps

module tb_top;

  // Result fields of one controller step.
  typedef struct packed {
    logic signed [pidpi_pkg::DataW-1:0] drive;
    logic signed [pidpi_pkg::ErrW-1:0]  error_now;
    logic signed [pidpi_pkg::DataW-1:0] integral_now;
  } pid_result_t;

  // Scoreboard: shadow controller state plus a queue of pending results.
  class pid_scoreboard;
    logic [47:0] gains;
    logic signed [15:0] setpoint;
    logic [30:0] limits;
    logic [31:0] thresholds;
    logic [15:0] alpha;
    logic [2:0] mode;
    bit running;
    longint sp_filt, integ, err_cur, err_prev, err_prev2, drive_reg, meas_last, meas_prev;
    pid_result_t pending_results[$];
    int errors;

    function void clear_all();
      gains = pidpi_pkg::GAINS_RST; setpoint = '0; limits = pidpi_pkg::LIMITS_RST;
      thresholds = pidpi_pkg::THRESHOLDS_RST; alpha = '0; mode = pidpi_pkg::MODE_RST;
      running = 0; sp_filt = 0; integ = 0; err_cur = 0; err_prev = 0;
      err_prev2 = 0; drive_reg = 0; meas_last = 0; meas_prev = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [pidpi_pkg::CfgIdxW-1:0] idx,
                            logic [pidpi_pkg::CfgDataW-1:0] val);
      case (idx)
        pidpi_pkg::REG_GAINS:      gains = val[47:0];
        pidpi_pkg::REG_SETPOINT:   setpoint = val[15:0];
        pidpi_pkg::REG_LIMITS:     limits = val[30:0];
        pidpi_pkg::REG_THRESHOLDS: thresholds = val[31:0];
        pidpi_pkg::REG_ALPHA:      alpha = val[15:0];
        pidpi_pkg::REG_MODE:       mode = val[2:0];
        default: ;
      endcase
    endfunction

    // Floor shift: >>> on longint is arithmetic.
    function longint gain_mul(longint g, longint v);
      longint p;
      p = g * v;
      return p >>> pidpi_pkg::GainFracBits;
    endfunction

    function longint clamp(longint v, longint b);
      if (v > b) return b;
      if (v < -b) return -b;
      return v;
    endfunction

    function longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void run_sample(longint meas);
      longint kp, ki, kd, max_out, max_int, dead, sep, sp_q, diff, hi, lo, err, d, o;
      kp = longint'(gains[47:32]); ki = longint'(gains[31:16]); kd = longint'(gains[15:0]);
      max_out = clamp(longint'(limits[30:16]), longint'(32767));
      max_int = clamp(longint'(limits[15:0]), longint'(32767));
      dead = longint'(thresholds[31:16]); sep = longint'(thresholds[15:0]);
      sp_q = longint'(setpoint) * 65536;
      meas_last = meas;
      if (alpha == 0) sp_filt = sp_q;
      else begin
        diff = sp_q - sp_filt;
        hi = diff >>> 16;
        lo = diff - hi * 65536;
        sp_filt += longint'(alpha) * hi + ((longint'(alpha) * lo) >>> 16);
      end
      err = (sp_filt >>> 16) - meas;
      if (absval(err) < dead) err = 0;
      err_cur = err;
      if (!mode[0]) begin
        if (!mode[1] || absval(err) < sep) integ = clamp(integ + err, max_int);
        if (mode[2]) d = gain_mul(kd, meas_prev - meas);
        else d = gain_mul(kd, err - err_prev);
        o = gain_mul(kp, err) + gain_mul(ki, integ) + d;
      end else begin
        integ = 0;
        o = drive_reg + gain_mul(kp, err - err_prev) + gain_mul(ki, err)
          + gain_mul(kd, err - 2 * err_prev + err_prev2);
      end
      drive_reg = clamp(o, max_out);
    endfunction

    // Note one accepted input transfer and queue its result.
    function void note_input(logic [pidpi_pkg::KindW-1:0] kind,
                             logic signed [pidpi_pkg::DataW-1:0] meas);
      pid_result_t r;
      case (kind)
        pidpi_pkg::KIND_SAMPLE: begin
          if (running) run_sample(longint'(meas));
          err_prev2 = err_prev; err_prev = err_cur; meas_prev = meas_last;
        end
        pidpi_pkg::KIND_STOP: begin
          running = 0; integ = 0; err_cur = 0; err_prev = 0; err_prev2 = 0;
          drive_reg = 0; meas_prev = meas_last;
        end
        pidpi_pkg::KIND_START: running = 1;
        default: ;
      endcase
      r.drive = drive_reg[15:0];
      r.error_now = err_cur[16:0];
      r.integral_now = integ[15:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(pid_result_t got);
      pid_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result drive=%0d err=%0d int=%0d", $time,
                 got.drive, got.error_now, got.integral_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.drive !== want.drive) begin
        $display("%0t: drive expected %0d actual %0d", $time, want.drive, got.drive);
        errors++;
      end
      if (got.error_now !== want.error_now) begin
        $display("%0t: error_now expected %0d actual %0d", $time,
                 want.error_now, got.error_now);
        errors++;
      end
      if (got.integral_now !== want.integral_now) begin
        $display("%0t: integral_now expected %0d actual %0d", $time,
                 want.integral_now, got.integral_now);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [pidpi_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pidpi_pkg::CfgDataW-1:0] cfg_data_i;

  pidpi_in_if  in_ch();
  pidpi_out_if out_ch();

  pid_position_incremental dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  pid_scoreboard sb;
  longint cycle_count;
  bit stall_long;   // request a long receiver hold-off

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Run watchdog: generous bound on total cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    pid_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.drive = out_ch.drive;
      got.error_now = out_ch.error_now;
      got.integral_now = out_ch.integral_now;
      sb.check_result(got);
    end
  end

  // Receiver: random ready with mostly short, sometimes long stalls; on request
  // hold off for a long stretch so the block backs up into its input.
  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_long) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk_i);
        stall_long = 0;
        out_ch.ready <= 1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        out_ch.ready <= 0;
        repeat (n) @(posedge clk_i);
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Offer one item and hold it until the transfer; note it in the scoreboard.
  task automatic send_item(logic [pidpi_pkg::KindW-1:0] kind,
                           logic signed [pidpi_pkg::DataW-1:0] meas, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.kind <= kind;
    in_ch.measurement <= meas;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(kind, meas);
    in_ch.valid <= 0;
    // the block is busy for at least this cycle after a transfer
    @(posedge clk_i);
  endtask

  // Drain all pending results, then let the block settle.
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(logic [pidpi_pkg::CfgIdxW-1:0] idx,
                           logic [pidpi_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // Sample with a mix of extremes, near-setpoint values and full-range noise.
  function automatic logic [15:0] pick_meas();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2: return 16'(sb.setpoint + $signed(16'($urandom_range(0, 400))) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return pidpi_pkg::KIND_SAMPLE;
    if (r < 93) return pidpi_pkg::KIND_START;
    if (r < 98) return pidpi_pkg::KIND_STOP;
    return pidpi_pkg::KIND_RSVD;  // unused kind, must leave the state unchanged
  endfunction

  // Random configuration, with extremes mixed in.
  task automatic random_config();
    logic [47:0] g;
    g = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) g = '1;
    else if ($urandom_range(0, 3) == 0) g = {16'($urandom_range(0, 1024)),
      16'($urandom_range(0, 512)), 16'($urandom_range(0, 512))};
    write_reg(pidpi_pkg::REG_GAINS, g);
    write_reg(pidpi_pkg::REG_SETPOINT,
              $urandom_range(0, 4) == 0 ? 48'h7fff : 48'($urandom));
    write_reg(pidpi_pkg::REG_LIMITS,
              $urandom_range(0, 4) == 0 ? 48'h7fffffff : 48'($urandom));
    write_reg(pidpi_pkg::REG_THRESHOLDS, $urandom_range(0, 2) == 0 ?
              48'($urandom_range(0, 50) << 16 | $urandom_range(0, 3000)) : 48'($urandom));
    write_reg(pidpi_pkg::REG_ALPHA, $urandom_range(0, 2) == 0 ? 48'd0 : 48'($urandom));
    write_reg(pidpi_pkg::REG_MODE, 48'($urandom_range(0, 7)));
  endtask

  initial begin
    int k;
    sb = new();
    sb.clear_all();
    cycle_count = 0;
    stall_long = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = pidpi_pkg::REG_GAINS;
    cfg_data_i = '0;
    in_ch.valid = 0;
    in_ch.kind = pidpi_pkg::KIND_SAMPLE;
    in_ch.measurement = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: stopped samples, unused kind, start, extremes, stop.
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sd123, 0);
    send_item(pidpi_pkg::KIND_RSVD, 16'sd5, 0);
    send_item(pidpi_pkg::KIND_START, 16'sd0, 0);
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sh7fff, 0);
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sh8000, 0);
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sd50, 0);
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sd0, 0);
    send_item(pidpi_pkg::KIND_STOP, 16'sd0, 0);
    send_item(pidpi_pkg::KIND_SAMPLE, 16'sd7, 0);
    drain();
    // Incremental mode with filter and dead zone, then extreme registers.
    write_reg(pidpi_pkg::REG_MODE, 48'd1);
    write_reg(pidpi_pkg::REG_ALPHA, 48'h4000);
    write_reg(pidpi_pkg::REG_SETPOINT, 48'h1000);
    write_reg(pidpi_pkg::REG_THRESHOLDS, 48'h0005_0064);
    send_item(pidpi_pkg::KIND_START, 16'sd0, 0);
    for (k = 0; k < 6; k++)
      send_item(pidpi_pkg::KIND_SAMPLE, k[0] ? 16'sh8000 : 16'sh0ffe, 0);
    drain();
    write_reg(pidpi_pkg::REG_GAINS, '1);
    write_reg(pidpi_pkg::REG_LIMITS, 48'h7fffffff);
    write_reg(pidpi_pkg::REG_ALPHA, 48'hffff);
    write_reg(pidpi_pkg::REG_SETPOINT, 48'h8000);
    write_reg(pidpi_pkg::REG_MODE, 48'd4);
    for (k = 0; k < 5; k++)
      send_item(pidpi_pkg::KIND_SAMPLE, k[0] ? 16'sh7fff : 16'sh8000, 0);
    drain();

    // Random phases, each under a fresh configuration.
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      send_item(pidpi_pkg::KIND_START, 16'sd0, 1);
      if (ph == 3) stall_long = 1;  // back the block up into its input
      for (k = 0; k < 70; k++) begin
        if (ph == 6 && k == 35) drain();  // sender pauses until all results are in
        send_item(pick_kind(), pick_meas(), ph != 3);
      end
      drain();
    end
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[files.f]
rtl/pidpi_pkg.sv
rtl/pidpi_if.sv
rtl/pid_position_incremental.sv
tb/sv/tb_top.sv
